>>> sv/pbr_pkg.sv
`default_nettype none

package pbr_pkg;

	// Geometry limits
	localparam int MAX_WIDTH = 4096;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WIDTH_W   = 13;
	localparam int FMT_W     = 3;

	// Source format codes; any other code gives black
	localparam logic [FMT_W-1:0] FMT_RGB555 = 3'd0;
	localparam logic [FMT_W-1:0] FMT_RGB565 = 3'd1;
	localparam logic [FMT_W-1:0] FMT_BGR24  = 3'd2;
	localparam logic [FMT_W-1:0] FMT_BGRX32 = 3'd3;

	// Register reset values
	localparam logic [FMT_W-1:0]   FMT_RESET   = FMT_RGB565;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd1;

	// Register index, taken from paddr bit 2
	localparam logic REG_FORMAT = 1'b0;
	localparam logic REG_WIDTH  = 1'b1;
	localparam int   ADDR_W     = 3;

	// Queue depths
	localparam int JOB_DEPTH = 2;
	localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);
	localparam int OUT_DEPTH = 2;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// Byte slots within one pixel job
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] IDX_BLUE  = 3'd0;
	localparam logic [IDX_W-1:0] IDX_GREEN = 3'd1;
	localparam logic [IDX_W-1:0] IDX_RED   = 3'd2;

	// One converted pixel waiting to be serialized
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [1:0] pad;
		logic       row_end;
	} job_t;

	// Back end status seen by the top level checks
	typedef struct packed {
		logic       emit;
		logic       is_pad;
		logic [7:0] data;
	} back_stat_t;

	// c*255/31 truncated: 8c plus floor(7c/31), found by threshold compares
	function automatic logic [7:0] widen5(input logic [4:0] c);
		logic [2:0] q;
		q = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
			+ 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
		return {c, 3'b000} + 8'(q);
	endfunction

	// c*255/63 truncated: 4c plus floor(c/21)
	function automatic logic [7:0] widen6(input logic [5:0] c);
		logic [1:0] q;
		q = 2'(c >= 6'd21) + 2'(c >= 6'd42) + 2'(c >= 6'd63);
		return {c, 2'b00} + 8'(q);
	endfunction

endpackage

`default_nettype wire

>>> sv/pixel_to_bgr24_row_packer_top.sv
// Pixel to BGR24 row packer.
// Input queue side: push and full; one transaction carries one source pixel in
// pixel_word, accepted when push is high and full is low.
// Output queue side: empty and pop; each transaction carries one byte in
// out_byte (blue, green, red, then zero pad bytes at a row end) and row_end,
// high on the last byte of a padded row.
// Configuration: APB write of source_format (0x0) and image_width (0x4) while
// the block is idle; pready is always high.
// Path: an accepted pixel is stored in the pixel queue; its blue byte then passes
// into the output queue, which drives out_byte, unless that queue is full.
// Throughput: one output byte per cycle while the output queue is not full, set by
// the single byte port; a pixel gives 3 bytes, plus one per pad byte at a row end (0 to 3).
// A two-entry pixel queue between the converter and the serializer lets
// pixels be pushed on consecutive cycles until it fills.
// When pop stays low the two-entry output queue fills, the serializer stops,
// the pixel queue fills and full rises; nothing is lost.
// Reset clears all queues and the column counter, and sets the format to
// RGB565 and the width to one pixel.
`default_nettype none

module pixel_to_bgr24_row_packer_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [31:0]                 pixel_word,
	input  wire logic                        pop,
	output logic                             empty,
	output logic [7:0]                       out_byte,
	output logic                             row_end,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pbr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	logic [pbr_pkg::FMT_W-1:0]     fmt_q;
	logic [pbr_pkg::WIDTH_W-1:0]   width_q;
	logic                          cfg_wr;
	logic                          accept;
	pbr_pkg::job_t                 front_job;
	pbr_pkg::job_t                 head_job;
	logic                          job_empty;
	logic                          job_done;
	logic [pbr_pkg::JOB_CNT_W-1:0] job_count;
	pbr_pkg::back_stat_t           back_stat;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= pbr_pkg::FMT_RESET;
			width_q <= pbr_pkg::WIDTH_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				pbr_pkg::REG_FORMAT: fmt_q   <= pwdata[pbr_pkg::FMT_W-1:0];
				pbr_pkg::REG_WIDTH:  width_q <= pwdata[pbr_pkg::WIDTH_W-1:0];
				default:             fmt_q   <= fmt_q;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[2])
			pbr_pkg::REG_FORMAT: prdata = 32'(fmt_q);
			pbr_pkg::REG_WIDTH:  prdata = 32'(width_q);
			default:             prdata = 32'd0;
		endcase
	end

	assign accept = push && !full;

	// Converter and column tracking
	pbr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.pixel_word    (pixel_word),
		.source_format (fmt_q),
		.image_width   (width_q),
		.job           (front_job)
	);

	// Pixel queue between front and back
	pbr_job_fifo u_job_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_job (front_job),
		.rd_en  (job_done),
		.rd_job (head_job),
		.full   (full),
		.empty  (job_empty),
		.count  (job_count)
	);

	// Byte serializer and output queue
	pbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!job_empty),
		.job       (head_job),
		.job_done  (job_done),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.row_end   (row_end),
		.stat      (back_stat)
	);

	// Checks
	a_job_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		job_count <= pbr_pkg::JOB_CNT_W'(pbr_pkg::JOB_DEPTH))
		else $error("pixel queue count above depth");

	a_pad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.emit && back_stat.is_pad |-> back_stat.data == 8'd0)
		else $error("pad byte not zero");

	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> job_count != '0)
		else $error("accepted pixel not queued");

	a_done_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_done |-> !job_empty && back_stat.emit)
		else $error("job retired without a queued pixel");

endmodule

`default_nettype wire

>>> sv/pbr_front.sv
`default_nettype none

module pbr_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [31:0]                   pixel_word,
	input  wire logic [pbr_pkg::FMT_W-1:0]     source_format,
	input  wire logic [pbr_pkg::WIDTH_W-1:0]   image_width,
	output pbr_pkg::job_t                      job
);

	logic [pbr_pkg::COL_W-1:0]   col_q;
	logic [pbr_pkg::WIDTH_W-1:0] eff_width;
	logic [pbr_pkg::COL_W-1:0]   last_col;
	logic                        at_row_end;
	logic [15:0]                 p16;

	// Clamp width to 1..MAX_WIDTH
	always_comb begin
		if (image_width == '0) begin
			eff_width = pbr_pkg::WIDTH_W'(1);
		end else if (image_width > pbr_pkg::WIDTH_W'(pbr_pkg::MAX_WIDTH)) begin
			eff_width = pbr_pkg::WIDTH_W'(pbr_pkg::MAX_WIDTH);
		end else begin
			eff_width = image_width;
		end
	end

	assign last_col   = pbr_pkg::COL_W'(eff_width - pbr_pkg::WIDTH_W'(1));
	assign at_row_end = (col_q >= last_col);
	assign p16        = pixel_word[15:0];

	// Format conversion to blue, green, red
	always_comb begin
		job.blue  = 8'd0;
		job.green = 8'd0;
		job.red   = 8'd0;
		case (source_format)
			pbr_pkg::FMT_RGB555: begin
				job.red   = pbr_pkg::widen5(p16[14:10]);
				job.green = pbr_pkg::widen5(p16[9:5]);
				job.blue  = pbr_pkg::widen5(p16[4:0]);
			end
			pbr_pkg::FMT_RGB565: begin
				job.red   = pbr_pkg::widen5(p16[15:11]);
				job.green = pbr_pkg::widen6(p16[10:5]);
				job.blue  = pbr_pkg::widen5(p16[4:0]);
			end
			pbr_pkg::FMT_BGR24, pbr_pkg::FMT_BGRX32: begin
				job.blue  = pixel_word[7:0];
				job.green = pixel_word[15:8];
				job.red   = pixel_word[23:16];
			end
			default: begin
				job.blue  = 8'd0;
			end
		endcase
		// 3*w bytes need (w mod 4) pad bytes to reach a multiple of four
		job.pad     = at_row_end ? eff_width[1:0] : 2'd0;
		job.row_end = at_row_end;
	end

	// Column counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (accept) begin
			col_q <= at_row_end ? '0 : col_q + pbr_pkg::COL_W'(1);
		end
	end

endmodule

`default_nettype wire

>>> sv/pbr_job_fifo.sv
`default_nettype none

module pbr_job_fifo (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire pbr_pkg::job_t                   wr_job,
	input  wire logic                            rd_en,
	output pbr_pkg::job_t                        rd_job,
	output logic                                 full,
	output logic                                 empty,
	output logic [pbr_pkg::JOB_CNT_W-1:0]        count
);

	pbr_pkg::job_t                 mem_q [pbr_pkg::JOB_DEPTH];
	logic [pbr_pkg::JOB_PTR_W-1:0] wr_ptr_q;
	logic [pbr_pkg::JOB_PTR_W-1:0] rd_ptr_q;
	logic [pbr_pkg::JOB_CNT_W-1:0] cnt_q;
	logic                          do_wr;
	logic                          do_rd;

	assign full   = (cnt_q == pbr_pkg::JOB_CNT_W'(pbr_pkg::JOB_DEPTH));
	assign empty  = (cnt_q == '0);
	assign count  = cnt_q;
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + pbr_pkg::JOB_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + pbr_pkg::JOB_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + pbr_pkg::JOB_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - pbr_pkg::JOB_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/pbr_back.sv
`default_nettype none

module pbr_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	input  wire pbr_pkg::job_t job,
	output logic               job_done,
	input  wire logic          pop,
	output logic               empty,
	output logic [7:0]         out_byte,
	output logic               row_end,
	output pbr_pkg::back_stat_t stat
);

	logic [pbr_pkg::IDX_W-1:0]     idx_q;
	logic [pbr_pkg::IDX_W-1:0]     last_idx;
	logic [7:0]                    byte_d;
	logic                          end_d;
	logic                          emit;
	logic                          out_full;
	logic                          do_pop;
	logic [7:0]                    ob_q [pbr_pkg::OUT_DEPTH];
	logic                          oe_q [pbr_pkg::OUT_DEPTH];
	logic [pbr_pkg::OUT_PTR_W-1:0] wr_ptr_q;
	logic [pbr_pkg::OUT_PTR_W-1:0] rd_ptr_q;
	logic [pbr_pkg::OUT_CNT_W-1:0] cnt_q;

	assign last_idx = pbr_pkg::IDX_RED + pbr_pkg::IDX_W'(job.pad);
	assign out_full = (cnt_q == pbr_pkg::OUT_CNT_W'(pbr_pkg::OUT_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_pop   = pop && !empty;
	assign emit     = job_valid && !out_full;
	assign job_done = emit && (idx_q == last_idx);
	assign end_d    = job.row_end && (idx_q == last_idx);

	// Byte select within the job
	always_comb begin
		case (idx_q)
			pbr_pkg::IDX_BLUE:  byte_d = job.blue;
			pbr_pkg::IDX_GREEN: byte_d = job.green;
			pbr_pkg::IDX_RED:   byte_d = job.red;
			default:            byte_d = 8'd0;
		endcase
	end

	assign stat.emit   = emit;
	assign stat.is_pad = (idx_q > pbr_pkg::IDX_RED);
	assign stat.data   = byte_d;

	// Byte slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (emit) begin
			idx_q <= job_done ? '0 : idx_q + pbr_pkg::IDX_W'(1);
		end
	end

	// Output queue storage
	always_ff @(posedge clk) begin
		if (emit) begin
			ob_q[wr_ptr_q] <= byte_d;
			oe_q[wr_ptr_q] <= end_d;
		end
	end

	assign out_byte = ob_q[rd_ptr_q];
	assign row_end  = oe_q[rd_ptr_q];

	// Output queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (emit) begin
				wr_ptr_q <= wr_ptr_q + pbr_pkg::OUT_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + pbr_pkg::OUT_PTR_W'(1);
			end
			if (emit && !do_pop) begin
				cnt_q <= cnt_q + pbr_pkg::OUT_CNT_W'(1);
			end else if (do_pop && !emit) begin
				cnt_q <= cnt_q - pbr_pkg::OUT_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> test/pixel_to_bgr24_row_packer_top_test.sv
`timescale 1ns / 100ps

module pixel_to_bgr24_row_packer_top_test;

	localparam int CLK_HALF    = 4;
	localparam int RESET_LEN   = 9;
	localparam int IDLE_PCT    = 37;
	localparam int TAIL_CYCLES = 8;
	localparam int RUN_LIMIT   = 200000;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 50;
	localparam int STEADY_ITEMS = 60;
	localparam int REPORT_CAP  = 20;

	// Codes outside the supported set all give black
	localparam logic [pbr_pkg::FMT_W-1:0] FMT_BLACK_LO = 3'd4;
	localparam logic [pbr_pkg::FMT_W-1:0] FMT_BLACK_HI = 3'd7;

	// One byte of packed row data
	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} row_byte_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         push       = 1'b0;
	logic [31:0]                  pixel_word = '0;
	logic                         pop        = 1'b0;
	logic                         psel       = 1'b0;
	logic                         penable    = 1'b0;
	logic                         pwrite     = 1'b0;
	logic [pbr_pkg::ADDR_W-1:0]   paddr      = '0;
	logic [31:0]                  pwdata     = '0;
	logic                         full;
	logic                         empty;
	logic [7:0]                   out_byte;
	logic                         row_end;
	logic [31:0]                  prdata;
	logic                         pready;

	// Local copy of the block's settings and row position
	logic [pbr_pkg::FMT_W-1:0]    fmt_setting   = pbr_pkg::FMT_RESET;
	logic [pbr_pkg::WIDTH_W-1:0]  width_setting = pbr_pkg::WIDTH_RESET;
	int                           column_now    = 0;

	row_byte_t                    row_bytes_due[$];
	row_byte_t                    head_byte;
	int                           mismatches = 0;
	int                           cycle_count;
	bit                           no_idle = 1'b0;

	pixel_to_bgr24_row_packer_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.pixel_word (pixel_word),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.row_end    (row_end),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #CLK_HALF clk = ~clk;

	// Scale a 5- or 6-bit channel to eight bits, truncating
	function automatic logic [7:0] scale_channel(input int code, input int top);
		return 8'((code * 255) / top);
	endfunction

	// Expected BGR bytes, pad bytes and row flag for one pixel
	function automatic void convert_pixel(input logic [31:0] word);
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] bytes[6];
		int         eff_width;
		int         count;
		bit         ends_row;
		blue  = '0;
		green = '0;
		red   = '0;
		eff_width = width_setting;
		if (eff_width == 0)
			eff_width = 1;
		if (eff_width > pbr_pkg::MAX_WIDTH)
			eff_width = pbr_pkg::MAX_WIDTH;
		case (fmt_setting)
			pbr_pkg::FMT_RGB555: begin
				red   = scale_channel(word[14:10], 31);
				green = scale_channel(word[9:5], 31);
				blue  = scale_channel(word[4:0], 31);
			end
			pbr_pkg::FMT_RGB565: begin
				red   = scale_channel(word[15:11], 31);
				green = scale_channel(word[10:5], 63);
				blue  = scale_channel(word[4:0], 31);
			end
			pbr_pkg::FMT_BGR24, pbr_pkg::FMT_BGRX32: begin
				blue  = word[7:0];
				green = word[15:8];
				red   = word[23:16];
			end
			default: ;
		endcase
		bytes = '{blue, green, red, 8'h00, 8'h00, 8'h00};
		count = 3;
		ends_row = (column_now + 1 >= eff_width);
		if (ends_row) begin
			count += (4 - ((eff_width * 3) & 3)) & 3;
			column_now = 0;
		end else begin
			column_now++;
		end
		for (int k = 0; k < count; k++)
			row_bytes_due.push_back(row_byte_t'{bytes[k], ends_row && (k == count - 1)});
	endfunction

	// Receiver: pop at random, or always during a steady stretch
	always @(negedge clk) begin
		pop <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Compare each popped byte with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (row_bytes_due.size() == 0) begin
				if (mismatches < REPORT_CAP)
					$display("%0t: unexpected transaction, expected none, got %h row_end %b",
						$time, out_byte, row_end);
				mismatches++;
			end else begin
				head_byte = row_bytes_due.pop_front();
				if (out_byte !== head_byte.value) begin
					if (mismatches < REPORT_CAP)
						$display("%0t: out_byte expected %h, got %h",
							$time, head_byte.value, out_byte);
					mismatches++;
				end
				if (row_end !== head_byte.last) begin
					if (mismatches < REPORT_CAP)
						$display("%0t: row_end expected %b, got %b",
							$time, head_byte.last, row_end);
					mismatches++;
				end
			end
		end
	end

	// Hard stop if the run hangs
	initial begin
		for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	// Push one pixel; returns at the falling edge after acceptance
	task automatic send_pixel(input logic [31:0] word);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push       <= 1'b1;
		pixel_word <= word;
		@(posedge clk);
		while (full)
			@(posedge clk);
		convert_pixel(word);
		@(negedge clk);
	endtask

	// Stop pushing and hold off until every expected byte is out
	task automatic wait_drained();
		push <= 1'b0;
		while (row_bytes_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// APB write: setup, access, then psel low before the task returns
	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= pbr_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == pbr_pkg::REG_FORMAT)
			fmt_setting = value[pbr_pkg::FMT_W-1:0];
		else
			width_setting = value[pbr_pkg::WIDTH_W-1:0];
		@(negedge clk);
	endtask

	// Each supported format code and two black codes with all-zero and all-one pixels, four-pixel rows
	task automatic test_formats();
		logic [pbr_pkg::FMT_W-1:0] codes[6];
		codes = '{pbr_pkg::FMT_RGB555, pbr_pkg::FMT_RGB565, pbr_pkg::FMT_BGR24,
			pbr_pkg::FMT_BGRX32, FMT_BLACK_LO, FMT_BLACK_HI};
		wait_drained();
		write_reg(pbr_pkg::REG_WIDTH, 32'd4);
		foreach (codes[i]) begin
			wait_drained();
			write_reg(pbr_pkg::REG_FORMAT, 32'(codes[i]));
			send_pixel(32'h0000_0000);
			send_pixel(32'hFFFF_FFFF);
		end
	endtask

	// Widths one to three give one, two and three pad bytes
	task automatic test_row_padding();
		wait_drained();
		write_reg(pbr_pkg::REG_FORMAT, 32'(pbr_pkg::FMT_BGR24));
		for (int w = 1; w <= 3; w++) begin
			wait_drained();
			write_reg(pbr_pkg::REG_WIDTH, 32'(w));
			for (int p = 0; p < w; p++)
				send_pixel($urandom());
		end
	endtask

	// Zero width acts as one; oversized width clamps; shrinking mid-row ends the row
	task automatic test_width_limits();
		wait_drained();
		write_reg(pbr_pkg::REG_WIDTH, 32'd0);
		send_pixel($urandom());
		wait_drained();
		write_reg(pbr_pkg::REG_WIDTH, 32'h1FFF);
		send_pixel($urandom());
		send_pixel($urandom());
		wait_drained();
		write_reg(pbr_pkg::REG_WIDTH, 32'd2);
		send_pixel($urandom());
	endtask

	// Random settings per phase; rows are left unfinished across phases
	task automatic test_random_traffic();
		logic [31:0] width_pick;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			write_reg(pbr_pkg::REG_FORMAT, 32'($urandom_range(0, 7)));
			case ($urandom_range(0, 9))
				0: width_pick = 0;
				1: width_pick = pbr_pkg::MAX_WIDTH;
				2: width_pick = $urandom_range(pbr_pkg::MAX_WIDTH + 1, 8191);
				default: width_pick = $urandom_range(1, 9);
			endcase
			write_reg(pbr_pkg::REG_WIDTH, width_pick);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_pixel($urandom());
		end
	endtask

	// Back-to-back pixels with the output always draining
	task automatic test_steady_stream();
		wait_drained();
		write_reg(pbr_pkg::REG_FORMAT, 32'(pbr_pkg::FMT_RGB555));
		write_reg(pbr_pkg::REG_WIDTH, 32'd5);
		no_idle = 1'b1;
		for (int n = 0; n < STEADY_ITEMS; n++)
			send_pixel($urandom());
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (RESET_LEN) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_formats();
		test_row_padding();
		test_width_limits();
		test_random_traffic();
		test_steady_stream();
		wait_drained();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
